// ===== rtl/core/ttg_pkg.sv =====
package ttg_pkg;

    localparam int NUM_CORES_DEF = 8;

    localparam int TEMP_W = 9;
    localparam int THR_W  = 7;
    localparam int HYST_W = 6;
    localparam int FREQ_W = 32;
    localparam int MASK_W = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [THR_W-1:0]  THR_RST  = 7'd60;
    localparam logic [HYST_W-1:0] HYST_RST = 6'd5;
    localparam logic [FREQ_W-1:0] WARM_RST = 32'd864000;
    localparam logic [FREQ_W-1:0] FULL_RST = 32'hFFFF_FFFF;
    localparam logic [FREQ_W-1:0] CAP_RST  = 32'hFFFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_HYSTERESIS = 3'd1,
        CFG_WARM_FREQ = 3'd2,
        CFG_FULL_FREQ = 3'd3,
        CFG_HOTPLUG_EN = 3'd4,
        CFG_CORE0_PERMIT = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [THR_W-1:0]  thr;
        logic [HYST_W-1:0] hyst;
        logic [FREQ_W-1:0] warm;
        logic [FREQ_W-1:0] full;
        logic              hp_en;
        logic              c0_permit;
    } cfg_t;

    // core count limited to the supported variants
    function automatic int core_clamp(input int n);
        int r;
        r = n;
        if (r < 4) r = 4;
        if (r > 8) r = 8;
        return r;
    endfunction

    function automatic logic [MASK_W-1:0] all_cores(input int n);
        logic [MASK_W:0] w;
        w = (9'd1 << core_clamp(n)) - 9'd1;
        return w[MASK_W-1:0];
    endfunction

endpackage

// ===== rtl/core/ttg_cfg.sv =====
module ttg_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ttg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ttg_pkg::CFG_DATA_W-1:0] cfg_data,
    output ttg_pkg::cfg_t                  cfg
);

    ttg_pkg::cfg_t cfg_reg;
    ttg_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                ttg_pkg::CFG_THRESHOLD:    cfg_next.thr = cfg_data[ttg_pkg::THR_W-1:0];
                ttg_pkg::CFG_HYSTERESIS:   cfg_next.hyst = cfg_data[ttg_pkg::HYST_W-1:0];
                ttg_pkg::CFG_WARM_FREQ:    cfg_next.warm = cfg_data[ttg_pkg::FREQ_W-1:0];
                ttg_pkg::CFG_FULL_FREQ:    cfg_next.full = cfg_data[ttg_pkg::FREQ_W-1:0];
                ttg_pkg::CFG_HOTPLUG_EN:   cfg_next.hp_en = cfg_data[0];
                ttg_pkg::CFG_CORE0_PERMIT: cfg_next.c0_permit = cfg_data[0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.thr       <= ttg_pkg::THR_RST;
            cfg_reg.hyst      <= ttg_pkg::HYST_RST;
            cfg_reg.warm      <= ttg_pkg::WARM_RST;
            cfg_reg.full      <= ttg_pkg::FULL_RST;
            cfg_reg.hp_en     <= 1'b1;
            cfg_reg.c0_permit <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/ttg_mask.sv =====
module ttg_mask
#(
    parameter int NUM_CORES = ttg_pkg::NUM_CORES_DEF
)
(
    input  logic signed [ttg_pkg::TEMP_W-1:0] temp,
    input  logic [ttg_pkg::MASK_W-1:0]        mask_cur,
    input  logic                              hp_en,
    input  logic                              c0_permit,
    output logic [ttg_pkg::MASK_W-1:0]        mask_new
);

    localparam int CORES = ttg_pkg::core_clamp(NUM_CORES);
    localparam logic [ttg_pkg::MASK_W-1:0] ALL = ttg_pkg::all_cores(NUM_CORES);

    logic [ttg_pkg::MASK_W-1:0] m;
    logic                       hot_band;

    always_comb
    begin
        m = mask_cur;
        hot_band = 1'b0;
        if (CORES >= 8)
        begin
            if (temp > 9'sd80)
            begin
                m = m & ~8'hCE;
                hot_band = 1'b1;
            end
            else if (temp > 9'sd55 && temp <= 9'sd65)
            begin
                m = (m | 8'hC0) & ~8'h0E;
                hot_band = 1'b1;
            end
            else if (temp > 9'sd45 && temp <= 9'sd50)
            begin
                m = (m | 8'h03) & ~8'h0C;
            end
            else if (temp == 9'sd40)
            begin
                m = ALL;
            end
        end
        else if (CORES >= 6)
        begin
            if (temp > 9'sd80)
            begin
                m = (m | 8'h0C) & ~8'h32;
                hot_band = 1'b1;
            end
            else if (temp > 9'sd55 && temp <= 9'sd65)
            begin
                m = (m | 8'h3C) & ~8'h02;
                hot_band = 1'b1;
            end
            else if (temp == 9'sd50)
            begin
                m = ALL;
            end
        end
        else
        begin
            if (temp > 9'sd80)
            begin
                m = m & ~8'h0E;
            end
            else if (temp > 9'sd70 && temp <= 9'sd75)
            begin
                m = (m | 8'h02) & ~8'h0C;
            end
            else if (temp > 9'sd60 && temp <= 9'sd65)
            begin
                m = (m | 8'h04) & ~8'h08;
            end
            else if (temp == 9'sd55)
            begin
                m = ALL;
            end
        end
        // core 0 takes the inverse of the permit bit in the hot bands of the six- and eight-core variants
        if (hot_band)
        begin
            m[0] = ~c0_permit;
        end
        mask_new = hp_en ? (m & ALL) : ALL;
    end

endmodule

// ===== rtl/core/ttg_freq.sv =====
module ttg_freq
(
    input  logic signed [ttg_pkg::TEMP_W-1:0] temp,
    input  ttg_pkg::cfg_t                     cfg,
    input  logic                              throttle_cur,
    input  logic [ttg_pkg::FREQ_W-1:0]        cap_cur,
    output logic                              throttle_new,
    output logic [ttg_pkg::FREQ_W-1:0]        cap_new,
    output logic                              changed
);

    logic signed [ttg_pkg::TEMP_W:0] t_x;
    logic signed [ttg_pkg::TEMP_W:0] thr_x;
    logic signed [ttg_pkg::TEMP_W:0] release_x;

    assign t_x       = {temp[ttg_pkg::TEMP_W-1], temp};
    assign thr_x     = signed'({3'b000, cfg.thr});
    assign release_x = thr_x - signed'({4'b0000, cfg.hyst});

    always_comb
    begin
        throttle_new = throttle_cur;
        cap_new      = cap_cur;
        changed      = 1'b0;
        if (throttle_cur && (t_x < release_x))
        begin
            cap_new      = cfg.full;
            changed      = (cap_cur != cfg.full);
            throttle_new = 1'b0;
        end
        else if ((t_x > thr_x) && (cfg.warm != '0))
        begin
            cap_new      = cfg.warm;
            changed      = (cap_cur != cfg.warm);
            throttle_new = 1'b1;
        end
    end

endmodule

// ===== rtl/core/thermal_throttle_hotplug_governor_core.sv =====
// channel  | valid          | stall          | payload
// ---------+----------------+----------------+--------------------------------------------
// sample   | sample_valid   | sample_stall   | temperature
// result   | result_valid   | result_stall   | freq_cap_khz, cap_changed, core_mask, throttling
// config   | cfg_we         | (none)         | cfg_index, cfg_data
//
// one sample per clock while the result is not stalled; a transferred sample is held in
// the sample register, which feeds the mask and cap logic; these load the result register,
// setting result valid, and the governor state in the same edge
// reset restores register defaults, clears throttling, sets cap to all ones and all cores on
// a stalled result holds the pipe; the sample register still takes one more sample while
// the result waits
module thermal_throttle_hotplug_governor_core
#(
    parameter int NUM_CORES = ttg_pkg::NUM_CORES_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_we,
    input  logic [ttg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ttg_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  logic signed [ttg_pkg::TEMP_W-1:0] temperature,

    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [ttg_pkg::FREQ_W-1:0]        freq_cap_khz,
    output logic                              cap_changed,
    output logic [ttg_pkg::MASK_W-1:0]        core_mask,
    output logic                              throttling
);

    localparam logic [ttg_pkg::MASK_W-1:0] ALL = ttg_pkg::all_cores(NUM_CORES);

    ttg_pkg::cfg_t cfg;

    // sample stage
    logic                              s1_valid_reg;
    logic                              s1_valid_next;
    logic signed [ttg_pkg::TEMP_W-1:0] s1_temp_reg;

    // governor state
    logic                              throttle_reg;
    logic [ttg_pkg::FREQ_W-1:0]        cap_reg;
    logic [ttg_pkg::MASK_W-1:0]        mask_reg;

    // result stage
    logic                              res_valid_reg;
    logic                              res_valid_next;
    logic [ttg_pkg::FREQ_W-1:0]        res_cap_reg;
    logic                              res_changed_reg;
    logic [ttg_pkg::MASK_W-1:0]        res_mask_reg;
    logic                              res_throttle_reg;

    logic                              advance;
    logic                              sample_xfer;
    logic                              process;

    logic [ttg_pkg::MASK_W-1:0]        mask_new;
    logic                              throttle_new;
    logic [ttg_pkg::FREQ_W-1:0]        cap_new;
    logic                              changed_new;

    ttg_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ttg_mask #(.NUM_CORES(NUM_CORES)) u_mask
    (
        .temp      (s1_temp_reg),
        .mask_cur  (mask_reg),
        .hp_en     (cfg.hp_en),
        .c0_permit (cfg.c0_permit),
        .mask_new  (mask_new)
    );

    ttg_freq u_freq
    (
        .temp         (s1_temp_reg),
        .cfg          (cfg),
        .throttle_cur (throttle_reg),
        .cap_cur      (cap_reg),
        .throttle_new (throttle_new),
        .cap_new      (cap_new),
        .changed      (changed_new)
    );

    // result register can take a new value when empty or being drained
    assign advance      = !res_valid_reg || !result_stall;
    assign process      = advance && s1_valid_reg;
    assign sample_stall = s1_valid_reg && !advance;
    assign sample_xfer  = sample_valid && !sample_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (sample_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        res_valid_next = advance ? s1_valid_reg : res_valid_reg;
    end

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            throttle_reg  <= 1'b0;
            cap_reg       <= ttg_pkg::CAP_RST;
            mask_reg      <= ALL;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (process)
            begin
                throttle_reg <= throttle_new;
                cap_reg      <= cap_new;
                mask_reg     <= mask_new;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (sample_xfer)
        begin
            s1_temp_reg <= temperature;
        end
        if (process)
        begin
            res_cap_reg      <= cap_new;
            res_changed_reg  <= changed_new;
            res_mask_reg     <= mask_new;
            res_throttle_reg <= throttle_new;
        end
    end

    assign result_valid = res_valid_reg;
    assign freq_cap_khz = res_cap_reg;
    assign cap_changed  = res_changed_reg;
    assign core_mask    = res_mask_reg;
    assign throttling   = res_throttle_reg;

`ifndef NO_ASSERTIONS
    // a shown result always mirrors the governor state it left behind
    a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_cap_reg == cap_reg && res_throttle_reg == throttle_reg
                           && res_mask_reg == mask_reg))
        else $error("result register out of step with governor state");

    // cores beyond the configured count never come online
    a_mask_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mask_reg & ~ALL) == '0)
        else $error("core mask has bits beyond core count");

    // a processed sample shows up as a result on the next cycle
    a_process_result: assert property (@(posedge clk) disable iff (!rst_n)
        process |=> res_valid_reg)
        else $error("processed sample did not produce a result");

    // the governor state only moves when a sample is processed
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !process |=> ($stable(cap_reg) && $stable(throttle_reg) && $stable(mask_reg)))
        else $error("governor state changed without a sample");
`endif

endmodule
